// ----- sv/utfd_pkg.sv -----
// ----------------------------------------------------------------------------
// utfd_pkg: shared types and constants of the utf-8 sequence decoder
// Lead byte limits, value limits and the classified window that travels
// from the front classifier through the queue to the back end.
// ----------------------------------------------------------------------------
package utfd_pkg;

  // lead byte limits
  localparam logic [7:0] LEAD_MIN_MULTI = 8'h80;
  localparam logic [7:0] LEAD_MIN_TWO   = 8'hc2;
  localparam logic [7:0] LEAD_MIN_THREE = 8'he0;
  localparam logic [7:0] LEAD_MIN_FOUR  = 8'hf0;
  localparam logic [7:0] LEAD_MAX_FOUR  = 8'hf4;

  // continuation byte form
  localparam logic [1:0] CONT_TAG = 2'b10;

  // smallest values of three- and four-byte forms, largest scalar value
  localparam logic [20:0] MIN_THREE  = 21'h000800;
  localparam logic [20:0] MIN_FOUR   = 21'h010000;
  localparam logic [20:0] MAX_SCALAR = 21'h10ffff;

  // window size
  localparam logic [2:0] WINDOW_BYTES = 3'd4;

  // classified window
  typedef struct packed {
    logic        empty;     // no bytes available
    logic        ascii;     // single-byte sequence
    logic        bad_lead;  // lead byte outside c2 to f4, ascii bytes included
    logic [2:0]  width;     // length announced by the lead byte
    logic [2:0]  avail;     // available count, clipped to the window
    logic [3:1]  cont;      // continuation form of bytes one to three
    logic [7:0]  lead;      // lead byte
    logic [17:0] tails;     // payload bits of bytes one to three, byte one high
  } cls_t;

  // queue status towards the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- sv/utfd_front.sv -----
// ----------------------------------------------------------------------------
// utfd_front: window classifier
// Splits an input beat into its bytes, clips the available count and
// classifies the lead byte and the continuation bytes.
// ----------------------------------------------------------------------------
module utfd_front (
  input  logic [39:0]     win_data,  // first, second, third, fourth byte, count
  output utfd_pkg::cls_t  cls
);

  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;
  logic [7:0] b3;
  logic [2:0] avail_raw;

  assign b0        = win_data[7:0];
  assign b1        = win_data[15:8];
  assign b2        = win_data[23:16];
  assign b3        = win_data[31:24];
  assign avail_raw = win_data[34:32];

  // classification of the window
  always_comb begin
    cls.avail    = (avail_raw > utfd_pkg::WINDOW_BYTES) ? utfd_pkg::WINDOW_BYTES : avail_raw;
    cls.empty    = (cls.avail == 3'd0);
    cls.ascii    = (b0 < utfd_pkg::LEAD_MIN_MULTI);
    cls.bad_lead = (b0 < utfd_pkg::LEAD_MIN_TWO) || (b0 > utfd_pkg::LEAD_MAX_FOUR);
    if (b0 < utfd_pkg::LEAD_MIN_MULTI) begin
      cls.width = 3'd1;
    end else if (b0 < utfd_pkg::LEAD_MIN_THREE) begin
      cls.width = 3'd2;
    end else if (b0 < utfd_pkg::LEAD_MIN_FOUR) begin
      cls.width = 3'd3;
    end else begin
      cls.width = 3'd4;
    end
    cls.cont[1] = (b1[7:6] == utfd_pkg::CONT_TAG);
    cls.cont[2] = (b2[7:6] == utfd_pkg::CONT_TAG);
    cls.cont[3] = (b3[7:6] == utfd_pkg::CONT_TAG);
    cls.lead    = b0;
    cls.tails   = {b1[5:0], b2[5:0], b3[5:0]};
  end

endmodule

// ----- sv/utfd_queue.sv -----
// ----------------------------------------------------------------------------
// utfd_queue: queue of classified windows
// Small first-in first-out store between the classifier and the back end,
// so that either side can stall on its own.
// ----------------------------------------------------------------------------
module utfd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  utfd_pkg::cls_t        push_data,
  input  logic                  pop,
  output utfd_pkg::cls_t        head,
  output utfd_pkg::q_status_t   status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  utfd_pkg::cls_t   store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = store_r[rd_ptr_r];
  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);

endmodule

// ----- sv/utfd_back.sv -----
// ----------------------------------------------------------------------------
// utfd_back: sequence decode and result register
// Assembles the code point, applies the overlong and range checks, works
// out the invalid span and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module utfd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  utfd_pkg::cls_t  head,
  input  logic            head_valid,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata   // sequence_length, code_value, skip_length
);

  logic [5:0]  t1;
  logic [5:0]  t2;
  logic [5:0]  t3;
  logic [20:0] value;
  logic        cont_ok;
  logic        short_win;
  logic        overlong;
  logic        seq_ok;
  logic [1:0]  span;
  logic [2:0]  len_nxt;
  logic [20:0] code_nxt;
  logic [1:0]  skip_nxt;
  logic        valid_r;
  logic        valid_nxt;
  logic [2:0]  len_r;
  logic [20:0] code_r;
  logic [1:0]  skip_r;

  assign t1 = head.tails[17:12];
  assign t2 = head.tails[11:6];
  assign t3 = head.tails[5:0];

  // code point assembly by announced length
  always_comb begin
    case (head.width)
      3'd2:    value = {10'd0, head.lead[4:0], t1};
      3'd3:    value = {5'd0, head.lead[3:0], t1, t2};
      3'd4:    value = {head.lead[2:0], t1, t2, t3};
      default: value = {13'd0, head.lead};
    endcase
  end

  // validity checks
  always_comb begin
    cont_ok   = ((head.width <= 3'd1) || head.cont[1]) &&
                ((head.width <= 3'd2) || head.cont[2]) &&
                ((head.width <= 3'd3) || head.cont[3]);
    short_win = (head.width > head.avail);
    overlong  = ((head.width == 3'd3) && (value < utfd_pkg::MIN_THREE)) ||
                ((head.width == 3'd4) && (value < utfd_pkg::MIN_FOUR)) ||
                (value > utfd_pkg::MAX_SCALAR);
    seq_ok    = !head.bad_lead && !short_win && cont_ok && !overlong;
  end

  // invalid span: up to the first non-continuation byte, else avail or width - 1
  always_comb begin
    if (head.bad_lead) begin
      span = 2'd1;
    end else if ((head.width > 3'd1) && (head.avail > 3'd1) && !head.cont[1]) begin
      span = 2'd1;
    end else if ((head.width > 3'd2) && (head.avail > 3'd2) && !head.cont[2]) begin
      span = 2'd2;
    end else if ((head.width > 3'd3) && (head.avail > 3'd3) && !head.cont[3]) begin
      span = 2'd3;
    end else if (short_win) begin
      span = head.avail[1:0];
    end else begin
      span = 2'(head.width - 3'd1);
    end
  end

  // result selection
  always_comb begin
    len_nxt  = 3'd0;
    code_nxt = '0;
    skip_nxt = 2'd0;
    if (head.empty) begin
      len_nxt = 3'd0;
    end else if (head.ascii) begin
      len_nxt  = 3'd1;
      code_nxt = {13'd0, head.lead};
    end else if (seq_ok) begin
      len_nxt  = head.width;
      code_nxt = value;
    end else begin
      skip_nxt = span;
    end
  end

  // output register handshake
  assign pop       = head_valid && (!valid_r || out_tready);
  assign valid_nxt = pop ? 1'b1 : (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      len_r  <= len_nxt;
      code_r <= code_nxt;
      skip_r <= skip_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, skip_r, code_r, len_r};

endmodule

// ----- sv/utf8_sequence_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_sequence_decoder: utf-8 sequence decoder
// Decodes the sequence at the start of a four-byte window into its length,
// code point and, for an invalid sequence, the length of the span to skip.
// ----------------------------------------------------------------------------
// The decoder takes one window per clock cycle and keeps that rate for as
// long as the result side takes a beat each cycle. An accepted window is
// written, classified, into a queue of QUEUE_DEPTH entries; the back end
// decodes the window at the queue head and loads the result into the
// output register when that register is empty or its beat is being taken.
// The result beat is then offered on out_tdata with out_tvalid high.
// While the result side is stalled the queue holds up to QUEUE_DEPTH
// classified windows behind the output register; in_tready falls only once
// the queue is full. Surrogate code points are reported as valid, and an
// available count above four counts as four.
module utf8_sequence_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // first_byte, second_byte, third_byte,
                                   // fourth_byte, bytes_available
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata    // sequence_length, code_value, skip_length
);

  utfd_pkg::cls_t      front_cls;
  utfd_pkg::cls_t      q_head;
  utfd_pkg::q_status_t q_status;
  logic                q_push;
  logic                q_pop;

  // front: classify the incoming window
  utfd_front u_front (
    .win_data (in_tdata),
    .cls      (front_cls)
  );

  assign in_tready = !q_status.full;
  assign q_push    = in_tvalid && in_tready;

  // queue between front and back
  utfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_cls),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  // back: decode and hold the result beat
  utfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_status.empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a valid sequence never carries a skip length
  a_len_no_skip : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[2:0] != 3'd0)) |-> (out_tdata[25:24] == 2'd0))
    else $error("valid sequence with nonzero skip length");

  // an invalid or empty result carries no code point
  a_invalid_zero_code : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[2:0] == 3'd0)) |-> (out_tdata[23:3] == 21'd0))
    else $error("invalid result with nonzero code value");

  // a decoded code point stays within the scalar range
  a_code_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:3] <= utfd_pkg::MAX_SCALAR))
    else $error("code value above scalar range");

  // the back end never takes from an empty queue
  a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // a beat accepted into an empty queue while the output register is free or being taken is popped in the next cycle
  a_queue_flow : assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_status.empty && (!out_tvalid || out_tready)) |=> q_pop)
    else $error("queued beat not taken by back end");

endmodule

// ----- test/utf8_sequence_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// utf8_sequence_decoder_tb: self-checking bench for the utf-8 sequence decoder
// Sends byte windows on the input stream and predicts every decoded result
// with its own decoder. Results are checked in order, field by field.
// Stimulus is a directed set of edge cases followed by random windows:
// mostly well-formed sequences, some overlong, out-of-range and corrupted
// forms, and some plain noise. Both sides stall at random, apart from one steady stretch.
// ----------------------------------------------------------------------------
module utf8_sequence_decoder_tb;

  // decoded result as it sits in out_tdata, lowest field last
  typedef struct packed {
    logic [1:0]  skip_length;
    logic [20:0] code_value;
    logic [2:0]  sequence_length;
  } decoded_t;

  // one expected result with the window that caused it
  typedef struct {
    logic [39:0] window;
    decoded_t    result;
  } pending_decode_t;

  // --------------------------------------------------------------------------
  // scoreboard: predicts each decode and checks results in arrival order
  // --------------------------------------------------------------------------
  class utf8_scoreboard;
    pending_decode_t pending_decodes[$];
    int              errors;

    function new();
      errors = 0;
    endfunction

    function bit is_continuation(logic [7:0] b);
      return b[7:6] == utfd_pkg::CONT_TAG;
    endfunction

    // decode of one window, with span to skip when invalid
    function decoded_t decode_window(logic [39:0] window);
      decoded_t    r;
      logic [7:0]  bytes [4];
      logic [7:0]  lead;
      logic [20:0] value;
      int          avail;
      int          width;
      bit          bad_lead;
      bit          ok;
      bit          found;
      r = '0;
      for (int i = 0; i < 4; i++) bytes[i] = window[i*8 +: 8];
      avail = window[34:32];
      if (avail > 4) avail = 4;
      if (avail == 0) return r;
      lead = bytes[0];
      if (lead < utfd_pkg::LEAD_MIN_MULTI) begin
        r.sequence_length = 3'd1;
        r.code_value = {14'd0, lead[6:0]};
        return r;
      end
      width = (lead < utfd_pkg::LEAD_MIN_THREE) ? 2 :
              (lead < utfd_pkg::LEAD_MIN_FOUR) ? 3 : 4;
      bad_lead = (lead < utfd_pkg::LEAD_MIN_TWO) || (lead > utfd_pkg::LEAD_MAX_FOUR);
      ok = !bad_lead && (width <= avail);
      value = 21'(lead & (8'h7f >> width));
      if (ok) begin
        for (int i = 1; i < width; i++) begin
          if (!is_continuation(bytes[i])) ok = 0;
          value = (value << 6) | 21'(bytes[i][5:0]);
        end
      end
      if (ok && ((width == 3 && value < utfd_pkg::MIN_THREE) ||
                 (width == 4 && value < utfd_pkg::MIN_FOUR) ||
                 value > utfd_pkg::MAX_SCALAR))
        ok = 0;
      if (ok) begin
        r.sequence_length = 3'(width);
        r.code_value = value;
        return r;
      end
      // invalid span
      if (bad_lead) begin
        r.skip_length = 2'd1;
        return r;
      end
      found = 0;
      for (int i = 1; i < width && i < avail; i++) begin
        if (!found && !is_continuation(bytes[i])) begin
          r.skip_length = 2'(i);
          found = 1;
        end
      end
      if (!found) r.skip_length = (avail < width) ? 2'(avail) : 2'(width - 1);
      return r;
    endfunction

    function void note_window(logic [39:0] window);
      pending_decode_t p;
      p.window = window;
      p.result = decode_window(window);
      pending_decodes.push_back(p);
    endfunction

    function void check_result(logic [31:0] beat);
      decoded_t        got;
      pending_decode_t p;
      got = beat[25:0];
      if (pending_decodes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat %h with nothing pending", beat);
        return;
      end
      p = pending_decodes.pop_front();
      if (got.sequence_length !== p.result.sequence_length ||
          got.code_value !== p.result.code_value ||
          got.skip_length !== p.result.skip_length) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch window %h: expected len %0d cp %h skip %0d, ",
                    "got len %0d cp %h skip %0d"},
                   p.window, p.result.sequence_length, p.result.code_value,
                   p.result.skip_length, got.sequence_length, got.code_value,
                   got.skip_length);
      end
    endfunction

    function int pending();
      return pending_decodes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // first_byte, second_byte, third_byte,
                            // fourth_byte, bytes_available
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // sequence_length, code_value, skip_length
  bit          steady_run;
  utf8_scoreboard board;

  utf8_sequence_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // beats on both sides, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_window(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_tready <= steady_run || ($urandom_range(0, 99) >= 31);
  end

  function automatic logic [39:0] pack_window(logic [7:0] b0, logic [7:0] b1,
                                              logic [7:0] b2, logic [7:0] b3,
                                              logic [2:0] avail);
    return {5'd0, avail, b3, b2, b1, b0};
  endfunction

  // utf-8 encoding of a value at a given length, spare bytes random
  function automatic logic [31:0] encode_seq(int width, logic [20:0] cp);
    logic [31:0] b;
    b = $urandom();
    case (width)
      1: b[7:0] = {1'b0, cp[6:0]};
      2: b[15:0] = {2'b10, cp[5:0], 3'b110, cp[10:6]};
      3: b[23:0] = {2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      default: b = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110,
                    cp[20:18]};
    endcase
    return b;
  endfunction

  // value that needs exactly the given length
  function automatic logic [20:0] pick_value(int width);
    case (width)
      1: return 21'($urandom_range(0, 'h7f));
      2: return 21'($urandom_range('h80, 'h7ff));
      3: return 21'($urandom_range('h800, 'hffff));
      default: return 21'($urandom_range('h10000, 'h10ffff));
    endcase
  endfunction

  // random window: mostly well-formed, then bad forms and noise
  function automatic logic [39:0] random_window();
    int          kind;
    int          width;
    int          pos;
    int          tag;
    logic [20:0] cp;
    logic [31:0] b;
    logic [2:0]  avail;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      width = $urandom_range(1, 4);
      b = encode_seq(width, pick_value(width));
      if ($urandom_range(0, 9) < 2) avail = 3'($urandom_range(0, width - 1));
      else avail = 3'($urandom_range(width, 7));
    end else if (kind < 70) begin
      // overlong or above the largest scalar
      width = $urandom_range(3, 4);
      if ($urandom_range(0, 1) == 0)
        cp = (width == 3) ? 21'($urandom_range(0, 'h7ff)) : 21'($urandom_range(0, 'hffff));
      else begin
        width = 4;
        cp = 21'($urandom_range('h110000, 'h1fffff));
      end
      b = encode_seq(width, cp);
      avail = 3'($urandom_range(width, 7));
    end else if (kind < 85) begin
      // one continuation byte with the wrong form
      width = $urandom_range(2, 4);
      b = encode_seq(width, pick_value(width));
      pos = $urandom_range(1, width - 1);
      tag = $urandom_range(0, 2);
      b[pos*8 +: 6] = 6'($urandom());
      b[pos*8+6 +: 2] = (tag == 2) ? 2'b11 : 2'(tag);
      avail = 3'($urandom_range(1, 7));
    end else begin
      b = $urandom();
      avail = 3'($urandom_range(0, 7));
    end
    return {5'd0, avail, b};
  endfunction

  // one window on the input stream, with a random gap ahead of it outside the steady run
  task automatic send_window(logic [39:0] window);
    if (!steady_run) begin
      while ($urandom_range(0, 99) < 31) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= window;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    steady_run = 1'b0;
    board = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed edge cases
    send_window(pack_window(8'hc3, 8'ha9, 8'h41, 8'hff, 3'd0));  // empty window
    send_window(pack_window(8'h00, 8'hff, 8'hff, 8'hff, 3'd1));
    send_window(pack_window(8'h7f, 8'h80, 8'h80, 8'h80, 3'd4));
    send_window(pack_window(8'h80, 8'h80, 8'h80, 8'h80, 3'd4));  // bare continuation
    send_window(pack_window(8'hbf, 8'h80, 8'h80, 8'h80, 3'd4));
    send_window(pack_window(8'hc0, 8'h80, 8'h00, 8'h00, 3'd2));  // bad two-byte leads
    send_window(pack_window(8'hc1, 8'hbf, 8'h00, 8'h00, 3'd4));
    send_window(pack_window(8'hc2, 8'h80, 8'h00, 8'h00, 3'd2));
    send_window(pack_window(8'hdf, 8'hbf, 8'hff, 8'hff, 3'd4));
    send_window(pack_window(8'he0, 8'ha0, 8'h80, 8'h00, 3'd3));
    send_window(pack_window(8'he0, 8'h9f, 8'hbf, 8'h00, 3'd3));  // overlong three-byte
    send_window(pack_window(8'hed, 8'ha0, 8'h80, 8'h00, 3'd3));  // surrogate
    send_window(pack_window(8'hed, 8'hbf, 8'hbf, 8'h00, 3'd4));
    send_window(pack_window(8'hef, 8'hbf, 8'hbf, 8'hff, 3'd3));
    send_window(pack_window(8'hf0, 8'h90, 8'h80, 8'h80, 3'd4));
    send_window(pack_window(8'hf0, 8'h8f, 8'hbf, 8'hbf, 3'd4));  // overlong four-byte
    send_window(pack_window(8'hf4, 8'h8f, 8'hbf, 8'hbf, 3'd4));
    send_window(pack_window(8'hf4, 8'h90, 8'h80, 8'h80, 3'd4));  // above the largest scalar
    send_window(pack_window(8'hf5, 8'h80, 8'h80, 8'h80, 3'd4));
    send_window(pack_window(8'hff, 8'hff, 8'hff, 8'hff, 3'd7));
    send_window(pack_window(8'he2, 8'h82, 8'hac, 8'h00, 3'd2));  // truncated
    send_window(pack_window(8'hf0, 8'h90, 8'h80, 8'h80, 3'd1));
    send_window(pack_window(8'he2, 8'h41, 8'hac, 8'h00, 3'd3));  // missing continuation
    send_window(pack_window(8'hf0, 8'h90, 8'hc0, 8'h80, 3'd4));
    send_window(pack_window(8'hc3, 8'ha9, 8'h00, 8'h00, 3'd7));  // count above four
    send_window(pack_window(8'hf4, 8'h8f, 8'hbf, 8'hbf, 3'd5));

    // random windows, with one long stretch free of stalls
    for (int i = 0; i < 950; i++) begin
      steady_run = (i >= 400 && i < 550);
      send_window(random_window());
    end
    steady_run = 1'b0;
    in_tvalid <= 1'b0;

    // drain
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/utfd_pkg.sv
sv/utfd_front.sv
sv/utfd_queue.sv
sv/utfd_back.sv
sv/utf8_sequence_decoder.sv
test/utf8_sequence_decoder_tb.sv
